// ----- rtl/tdfs_pkg.sv -----
// Package for the timer divisor factor search unit.
// Holds the fixed datapath widths, the clock register reset value and the subtractor flag type.
// No dependencies.
package tdfs_pkg;

  // width of the clock and frequency words, and of the core quotient
  localparam int unsigned DIV_WIDTH = 32;

  // shared subtractor width: divider remainder plus guard bits
  localparam int unsigned SUB_WIDTH = DIV_WIDTH + 2;

  // core clock register value after reset
  localparam logic [DIV_WIDTH-1:0] CORE_CLOCK_RESET = 32'd48000000;

  // flags that leave the shared subtractor
  typedef struct packed {
    logic borrow;
    logic zero;
  } sub_flags_t;

endpackage

// ----- rtl/timer_divisor_factor_search_unit.sv -----
// Timer divisor factor search unit: top level, single module.
// Uses tdfs_pkg for widths, the reset clock value and the subtractor flags.
//
// Usage
//   cfg_wr_en / cfg_wr_data write core_clock_hz (reset value 48 MHz). Write it
//   only while the unit is idle.
//   Input word: in_wanted_freq_hz on in_valid, accepted when in_stall is low.
//   Output word: out_prescale_value, out_reload_value, out_div_error on
//   out_valid, taken when out_stall is low. Exactly one output per input.
//   in_stall is high from the accepting edge until the result has been moved
//   into the output register; a held output does not block the next input.
// Sequence from accept to result in the output register
//   zero frequency: straight to the hand-over, zero results, error flag set.
//   otherwise: clock / frequency divide, square root, rounding, then for
//   each candidate divisor tried a COUNT_WIDTH-step restoring divide plus
//   a check, then the hand-over to the output register. All steps run on
//   one shared subtractor, one bit (two bits for the root) per cycle.
//   At COUNT_WIDTH = 32 the worst case tries about 65536 candidates.
// The unit works on one word at a time; the next word can be taken in the
//   cycle after the result moves into the output register.
// Reset (synchronous, rst_n low) returns the sequencer to idle, drops
//   out_valid and restores core_clock_hz. If the receiver stalls, the result
//   holds in the output register and the finished next result waits in the
//   sequencer until the output register frees.
module timer_divisor_factor_search_unit
  import tdfs_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_wr_en,
  input  logic [DIV_WIDTH-1:0] cfg_wr_data,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [DIV_WIDTH-1:0] in_wanted_freq_hz,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DIV_WIDTH-1:0] out_prescale_value,
  output logic [DIV_WIDTH-1:0] out_reload_value,
  output logic                 out_div_error
);

  // root iterations, and alignment shifts for the MSB-first shift register
  localparam int unsigned SQW    = (COUNT_WIDTH + 1) / 2;
  localparam int unsigned SQ_SH  = DIV_WIDTH - 2 * SQW;
  localparam int unsigned MOD_SH = DIV_WIDTH - COUNT_WIDTH;
  localparam int unsigned SW     = SUB_WIDTH;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQRT,
    ST_ROUND,
    ST_MOD,
    ST_CHECK,
    ST_FIN
  } state_t;

  state_t                 state_r, state_nxt;
  logic [DIV_WIDTH-1:0]   clk_hz_r, clk_hz_nxt;
  logic [SW-1:0]          rem_r, rem_nxt;
  logic [DIV_WIDTH-1:0]   quo_r, quo_nxt;
  logic [DIV_WIDTH-1:0]   den_r, den_nxt;
  logic [5:0]             cnt_r, cnt_nxt;
  logic [COUNT_WIDTH-1:0] n_r, n_nxt;
  logic [SQW-1:0]         root_r, root_nxt;
  logic [SQW:0]           d_r, d_nxt;
  logic [DIV_WIDTH-1:0]   psc_r, psc_nxt;
  logic [DIV_WIDTH-1:0]   arr_r, arr_nxt;
  logic                   err_r, err_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [DIV_WIDTH-1:0]   out_psc_r, out_psc_nxt;
  logic [DIV_WIDTH-1:0]   out_arr_r, out_arr_nxt;
  logic                   out_err_r, out_err_nxt;

  // shared subtractor
  logic [SW-1:0] sub_a, sub_b;
  logic [SW:0]   sub_diff;
  sub_flags_t    sub_flags;

  logic [SW-1:0]          div_sh;
  logic [SW-1:0]          sq_sh;
  logic [DIV_WIDTH-1:0]   div_q;
  logic [COUNT_WIDTH-1:0] n_sat;
  logic                   in_acc;
  logic                   out_free;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // partial remainders shifted by one bit (divide) or two bits (root)
  assign div_sh = {rem_r[SW-2:0], quo_r[DIV_WIDTH-1]};
  assign sq_sh  = {rem_r[SW-3:0], quo_r[DIV_WIDTH-1 -: 2]};

  // quotient including the bit decided this cycle
  assign div_q = {quo_r[DIV_WIDTH-2:0], !sub_flags.borrow};

  // saturate the core quotient to the count width
  assign n_sat = ((div_q >> COUNT_WIDTH) != '0) ? '1 : div_q[COUNT_WIDTH-1:0];

  // operand select for the subtractor
  always_comb begin
    case (state_r)
      ST_SQRT: begin
        sub_a = sq_sh;
        sub_b = SW'({root_r, 2'b01});
      end
      ST_ROUND: begin
        sub_a = SW'(root_r);
        sub_b = rem_r;
      end
      ST_DIV, ST_MOD: begin
        sub_a = div_sh;
        sub_b = SW'(den_r);
      end
      default: begin
        sub_a = rem_r;
        sub_b = '0;
      end
    endcase
  end

  assign sub_diff  = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_flags = {sub_diff[SW], (sub_diff[SW-1:0] == '0)};

  // sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    clk_hz_nxt    = clk_hz_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    den_nxt       = den_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    root_nxt      = root_r;
    d_nxt         = d_r;
    psc_nxt       = psc_r;
    arr_nxt       = arr_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r;
    out_psc_nxt   = out_psc_r;
    out_arr_nxt   = out_arr_r;
    out_err_nxt   = out_err_r;

    if (cfg_wr_en) begin
      clk_hz_nxt = cfg_wr_data;
    end

    // output word leaves
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_wanted_freq_hz == '0) begin
            psc_nxt   = '0;
            arr_nxt   = '0;
            err_nxt   = 1'b1;
            state_nxt = ST_FIN;
          end else begin
            rem_nxt   = '0;
            quo_nxt   = clk_hz_r;
            den_nxt   = in_wanted_freq_hz;
            cnt_nxt   = 6'(DIV_WIDTH - 1);
            err_nxt   = 1'b0;
            state_nxt = ST_DIV;
          end
        end
      end

      // total count = clock / frequency, one quotient bit a cycle
      ST_DIV: begin
        if (!sub_flags.borrow) begin
          rem_nxt = sub_diff[SW-1:0];
          quo_nxt = {quo_r[DIV_WIDTH-2:0], 1'b1};
        end else begin
          rem_nxt = div_sh;
          quo_nxt = {quo_r[DIV_WIDTH-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == '0) begin
          n_nxt     = n_sat;
          quo_nxt   = DIV_WIDTH'(n_sat) << SQ_SH;
          rem_nxt   = '0;
          root_nxt  = '0;
          cnt_nxt   = 6'(SQW - 1);
          state_nxt = ST_SQRT;
        end
      end

      // digit-by-digit floor root, two count bits a cycle
      ST_SQRT: begin
        if (!sub_flags.borrow) begin
          rem_nxt  = sub_diff[SW-1:0];
          root_nxt = {root_r[SQW-2:0], 1'b1};
        end else begin
          rem_nxt  = sq_sh;
          root_nxt = {root_r[SQW-2:0], 1'b0};
        end
        quo_nxt = {quo_r[DIV_WIDTH-3:0], 2'b00};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == '0) begin
          state_nxt = ST_ROUND;
        end
      end

      // round up when the root remainder exceeds the root
      ST_ROUND: begin
        d_nxt = (SQW+1)'(root_r) + (SQW+1)'(sub_flags.borrow);
        if (!sub_flags.borrow && root_r == '0) begin
          // zero count: nothing to search
          psc_nxt   = '0;
          arr_nxt   = '0;
          state_nxt = ST_FIN;
        end else begin
          rem_nxt   = '0;
          quo_nxt   = DIV_WIDTH'(n_r) << MOD_SH;
          den_nxt   = DIV_WIDTH'(d_nxt);
          cnt_nxt   = 6'(COUNT_WIDTH - 1);
          state_nxt = ST_MOD;
        end
      end

      // count / candidate, one quotient bit a cycle
      ST_MOD: begin
        if (!sub_flags.borrow) begin
          rem_nxt = sub_diff[SW-1:0];
          quo_nxt = {quo_r[DIV_WIDTH-2:0], 1'b1};
        end else begin
          rem_nxt = div_sh;
          quo_nxt = {quo_r[DIV_WIDTH-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == '0) begin
          state_nxt = ST_CHECK;
        end
      end

      // exact divisor ends the search, else step the candidate down
      ST_CHECK: begin
        if (sub_flags.zero) begin
          psc_nxt   = DIV_WIDTH'(d_r);
          arr_nxt   = DIV_WIDTH'(quo_r[COUNT_WIDTH-1:0]);
          state_nxt = ST_FIN;
        end else begin
          d_nxt     = d_r - (SQW+1)'(1);
          rem_nxt   = '0;
          quo_nxt   = DIV_WIDTH'(n_r) << MOD_SH;
          den_nxt   = DIV_WIDTH'(d_nxt);
          cnt_nxt   = 6'(COUNT_WIDTH - 1);
          state_nxt = ST_MOD;
        end
      end

      // hand the result to the output register once it is free
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_psc_nxt   = psc_r;
          out_arr_nxt   = arr_r;
          out_err_nxt   = err_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state, control, datapath and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      clk_hz_r    <= CORE_CLOCK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clk_hz_r    <= clk_hz_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    den_r     <= den_nxt;
    cnt_r     <= cnt_nxt;
    n_r       <= n_nxt;
    root_r    <= root_nxt;
    d_r       <= d_nxt;
    psc_r     <= psc_nxt;
    arr_r     <= arr_nxt;
    err_r     <= err_nxt;
    out_psc_r <= out_psc_nxt;
    out_arr_r <= out_arr_nxt;
    out_err_r <= out_err_nxt;
  end

  assign in_stall           = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_prescale_value = out_psc_r;
  assign out_reload_value   = out_arr_r;
  assign out_div_error      = out_err_r;

  // an error word always carries zero results
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_div_error) |-> (out_prescale_value == '0 && out_reload_value == '0))
    else $error("error word with nonzero results");

  // no prescale found means no reload either
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_prescale_value == '0) |-> (out_reload_value == '0))
    else $error("reload without prescale");

  // an accepted word closes the input until the sequencer is done
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open right after accept");

  // the candidate divisor is never zero while dividing
  a_cand: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MOD) |-> (d_r != '0))
    else $error("zero candidate divisor");

endmodule
